// ----- rtl/assert_macros.svh -----
// Assertion helpers used by rpqs_ctrl.
// Each use names its label, its property and its message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk, skipped while rst_n is low.
`define RPQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge of clk, reset cycles included.
`define RPQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rpqs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpqs_pkg
// Shared widths, command codes and constants of the range predecessor store.
// ----------------------------------------------------------------------------
package rpqs_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 31;
  localparam int ANS_W = 32;

  localparam int DEPTH_DEFAULT = 1024;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Answer given when no stored value in the range lies below the key
  localparam logic [ANS_W-1:0] ANS_NONE = {ANS_W{1'b1}};

endpackage
`default_nettype wire

// ----- rtl/rpqs_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpqs_mem
// Value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpqs_mem #(
  parameter int DEPTH = rpqs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [rpqs_pkg::VAL_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [rpqs_pkg::VAL_W-1:0] rd_data
);
  import rpqs_pkg::*;

  logic [VAL_W-1:0] store_r [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/rpqs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpqs_ctrl
// Command decode, scan sequencer, running best below the key and result
// register.
// ----------------------------------------------------------------------------
module rpqs_ctrl #(
  parameter int DEPTH = rpqs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_command,
  input  wire logic [rpqs_pkg::POS_W-1:0] in_position,
  input  wire logic [rpqs_pkg::VAL_W-1:0] in_value,
  input  wire logic [rpqs_pkg::POS_W-1:0] in_range_start,
  input  wire logic [rpqs_pkg::POS_W-1:0] in_range_end,
  input  wire logic [rpqs_pkg::VAL_W-1:0] in_key,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [rpqs_pkg::ANS_W-1:0] out_answer,
  output logic                            mem_we,
  output logic      [$clog2(DEPTH)-1:0]   mem_waddr,
  output logic      [rpqs_pkg::VAL_W-1:0] mem_wdata,
  output logic                            mem_re,
  output logic      [$clog2(DEPTH)-1:0]   mem_raddr,
  input  wire logic [rpqs_pkg::VAL_W-1:0] mem_rdata
);
  import rpqs_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > POS_W) ? AW : POS_W;
  localparam logic [CW-1:0] LAST_POS = CW'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    end_r;
  logic [VAL_W-1:0] key_r;
  logic [VAL_W-1:0] best_r;
  logic             found_r;
  logic             rd_vld_r;
  logic             out_valid_r;
  logic [ANS_W-1:0] out_answer_r;

  logic          accept;
  logic          is_query;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] start_ext;
  logic [CW-1:0] end_ext;
  logic [CW-1:0] end_clamp;
  logic          range_empty;
  logic          last_issue;
  logic          hit;
  logic          load_out;

  // Decode the incoming command and clamp the range to the store
  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign is_query    = (in_command == CMD_QUERY);
  assign pos_ext     = CW'(in_position);
  assign start_ext   = CW'(in_range_start);
  assign end_ext     = CW'(in_range_end);
  assign end_clamp   = (end_ext > LAST_POS) ? LAST_POS : end_ext;
  assign range_empty = (start_ext > end_clamp);

  // Write path: positions beyond the store are dropped
  assign mem_we    = accept && (in_command == CMD_WRITE) && (pos_ext <= LAST_POS);
  assign mem_waddr = pos_ext[AW-1:0];
  assign mem_wdata = in_value;

  // Scan path: one read per cycle, compared in the following cycle
  assign mem_re     = (state_r == ST_SCAN);
  assign mem_raddr  = addr_r;
  assign last_issue = (addr_r == end_r);
  assign hit        = rd_vld_r && (mem_rdata < key_r) && (!found_r || (mem_rdata > best_r));
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_nxt = range_empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_re;
      if (accept && is_query) begin
        found_r <= 1'b0;
      end else if (hit) begin
        found_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: scan bounds, key, running best, result
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      key_r  <= in_key;
      addr_r <= start_ext[AW-1:0];
      end_r  <= end_clamp[AW-1:0];
    end else if (mem_re && !last_issue) begin
      addr_r <= addr_r + AW'(1);
    end
    if (hit) begin
      best_r <= mem_rdata;
    end
    if (load_out) begin
      out_answer_r <= found_r ? {1'b0, best_r} : ANS_NONE;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;

  `RPQS_ASSERT(a_rd_in_scan, rd_vld_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN), "read data outside a scan")
  `RPQS_ASSERT(a_addr_bound, (state_r == ST_SCAN) |-> (addr_r <= end_r), "scan address past range end")
  `RPQS_ASSERT(a_load_shows, load_out |=> out_valid_r, "result load not shown")
  `RPQS_ASSERT(a_no_wr_scan, mem_we |-> !(rd_vld_r || mem_re), "write during a scan")
  `RPQS_ASSERT_ALWAYS(a_best_below, (rst_n && found_r) |-> (best_r < key_r), "best not below key")

endmodule
`default_nettype wire

// ----- rtl/range_predecessor_query_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A write enters the store at the edge that accepts it. A query moves through
// the scan, drain and done states before its answer shows; an empty range
// goes straight to done. One item at a time: a query holds the input until its
// answer is loaded, the single store read port scanning one entry per cycle.
// Reset clears control state only; store contents are undefined until written.
// ----------------------------------------------------------------------------
// range_predecessor_query_store
// Point-write value store answering the largest value below a key in a range.
// ----------------------------------------------------------------------------
module range_predecessor_query_store #(
  parameter int DEPTH = rpqs_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_command,
  input  wire logic [rpqs_pkg::POS_W-1:0] in_position,
  input  wire logic [rpqs_pkg::VAL_W-1:0] in_value,
  input  wire logic [rpqs_pkg::POS_W-1:0] in_range_start,
  input  wire logic [rpqs_pkg::POS_W-1:0] in_range_end,
  input  wire logic [rpqs_pkg::VAL_W-1:0] in_key,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [rpqs_pkg::ANS_W-1:0] out_answer
);
  import rpqs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  // Sequencer and result register
  rpqs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_value       (in_value),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_answer     (out_answer),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  // Value store
  rpqs_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule
`default_nettype wire
